@@ src/assert_macros.svh @@
// Assertion helpers shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, switched off while reset is held.
`define LIR_ASSERT(lbl, ck, rn, prop) \
  lbl: assert property (@(posedge ck) disable iff (!rn) prop) \
    else $error("%m: check failed");

// Clocked check that also runs through reset.
`define LIR_ASSERT_RST(lbl, ck, prop) \
  lbl: assert property (@(posedge ck) prop) \
    else $error("%m: check failed");

`endif

@@ src/lir_pkg.sv @@
`default_nettype none

package lir_pkg;

  localparam int unsigned LIR_LANES     = 8;
  localparam int unsigned LIR_LANE_W    = $clog2(LIR_LANES);
  localparam int unsigned LIR_SAMPLE_W  = 32;
  localparam int unsigned LIR_WIDE_W    = LIR_SAMPLE_W + 3;
  localparam int unsigned LIR_RATE_W    = 18;
  localparam int unsigned LIR_CHAN_W    = 4;
  localparam int unsigned LIR_LIMIT_W   = 16;
  localparam int unsigned LIR_CNT_W     = 17;
  localparam int unsigned LIR_POS_W     = 32;
  localparam int unsigned LIR_FRAC_W    = 16;
  localparam int unsigned LIR_DIVD_W    = LIR_RATE_W + LIR_FRAC_W;
  localparam int unsigned LIR_MAX_RUN   = 25;
  localparam int unsigned LIR_RUN_W     = $clog2(LIR_MAX_RUN + 1);
  localparam int unsigned LIR_CFG_IDX_W = 2;

  localparam logic [LIR_POS_W-1:0] LIR_MIN_STEP = LIR_POS_W'(2730);
  localparam logic [LIR_CNT_W-1:0] LIR_CNT_MAX  = '1;

  localparam logic LIR_FMT_S16 = 1'b0;
  localparam logic LIR_FMT_S32 = 1'b1;

  localparam logic signed [LIR_WIDE_W-1:0] LIR_S16_MAX = 35'sd32767;
  localparam logic signed [LIR_WIDE_W-1:0] LIR_S16_MIN = -35'sd32768;
  localparam logic signed [LIR_WIDE_W-1:0] LIR_S32_MAX = 35'sd2147483647;
  localparam logic signed [LIR_WIDE_W-1:0] LIR_S32_MIN = -35'sd2147483648;

  typedef enum logic [LIR_CFG_IDX_W-1:0] {
    CFG_SOURCE_RATE   = 2'd0,
    CFG_TARGET_RATE   = 2'd1,
    CFG_CHANNEL_COUNT = 2'd2,
    CFG_SAMPLE_FORMAT = 2'd3
  } lir_cfg_idx_t;

  typedef logic signed [LIR_SAMPLE_W-1:0] lir_sample_t;

  // One lane job for the shared interpolation unit.
  typedef struct packed {
    logic                  valid;
    logic [LIR_LANE_W-1:0] lane;
    lir_sample_t           s0;
    lir_sample_t           s1;
    logic [LIR_FRAC_W-1:0] frac;
  } lir_req_t;

  typedef struct packed {
    logic                  valid;
    logic [LIR_LANE_W-1:0] lane;
    lir_sample_t           value;
  } lir_res_t;

  // Clamp a widened value to the range of the sample format.
  function automatic lir_sample_t sat_fmt(input logic signed [LIR_WIDE_W-1:0] v,
                                          input logic fmt);
    logic signed [LIR_WIDE_W-1:0] hi;
    logic signed [LIR_WIDE_W-1:0] lo;
    hi = (fmt == LIR_FMT_S32) ? LIR_S32_MAX : LIR_S16_MAX;
    lo = (fmt == LIR_FMT_S32) ? LIR_S32_MIN : LIR_S16_MIN;
    if (v > hi) begin
      sat_fmt = hi[LIR_SAMPLE_W-1:0];
    end else if (v < lo) begin
      sat_fmt = lo[LIR_SAMPLE_W-1:0];
    end else begin
      sat_fmt = v[LIR_SAMPLE_W-1:0];
    end
  endfunction

endpackage

`default_nettype wire

@@ src/lir_ifs.sv @@
`default_nettype none

interface lir_in_if;
  logic                                valid;
  logic                                ready;
  logic                                block_start;
  logic [lir_pkg::LIR_LIMIT_W-1:0]     output_limit;
  lir_pkg::lir_sample_t                sample_in_0;
  lir_pkg::lir_sample_t                sample_in_1;
  lir_pkg::lir_sample_t                sample_in_2;
  lir_pkg::lir_sample_t                sample_in_3;
  lir_pkg::lir_sample_t                sample_in_4;
  lir_pkg::lir_sample_t                sample_in_5;
  lir_pkg::lir_sample_t                sample_in_6;
  lir_pkg::lir_sample_t                sample_in_7;

  modport source (
    output valid, block_start, output_limit,
    output sample_in_0, sample_in_1, sample_in_2, sample_in_3,
    output sample_in_4, sample_in_5, sample_in_6, sample_in_7,
    input  ready
  );

  modport sink (
    input  valid, block_start, output_limit,
    input  sample_in_0, sample_in_1, sample_in_2, sample_in_3,
    input  sample_in_4, sample_in_5, sample_in_6, sample_in_7,
    output ready
  );
endinterface

interface lir_out_if;
  logic                 valid;
  logic                 ready;
  lir_pkg::lir_sample_t sample_out_0;
  lir_pkg::lir_sample_t sample_out_1;
  lir_pkg::lir_sample_t sample_out_2;
  lir_pkg::lir_sample_t sample_out_3;
  lir_pkg::lir_sample_t sample_out_4;
  lir_pkg::lir_sample_t sample_out_5;
  lir_pkg::lir_sample_t sample_out_6;
  lir_pkg::lir_sample_t sample_out_7;
  logic                 last_of_run;

  modport source (
    output valid, last_of_run,
    output sample_out_0, sample_out_1, sample_out_2, sample_out_3,
    output sample_out_4, sample_out_5, sample_out_6, sample_out_7,
    input  ready
  );

  modport sink (
    input  valid, last_of_run,
    input  sample_out_0, sample_out_1, sample_out_2, sample_out_3,
    input  sample_out_4, sample_out_5, sample_out_6, sample_out_7,
    output ready
  );
endinterface

`default_nettype wire

@@ src/linear_interp_resampler.sv @@
`default_nettype none

// Channel  Dir  Handshake          Payload
// in_ch    in   valid/ready        block_start, output_limit, sample_in_0..7
// out_ch   out  valid/ready        sample_out_0..7, last_of_run
// cfg_*    in   cfg_we (no ready)  cfg_index (2 bit), cfg_data (18 bit)
//
// One item is worked on at a time; in_ch.ready is high only in the idle state.
// An item with block_start first waits for the step (src << 16) / dst, which
// comes from a serial divider, one quotient bit per cycle.
// Each output frame sends 8 lane jobs through the shared
// subtract-multiply-round unit, drains it, then hands the frame off.
// Per item: up to 25 output frames.
// The result register lets the next item in while the last frame waits;
// a stalled out_ch holds the sequencer before the next frame is handed off.
// Reset (rst_n low, synchronous) restores the register defaults and clears
// position, counts, step and limit.
module linear_interp_resampler (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [lir_pkg::LIR_CFG_IDX_W-1:0]   cfg_index,
  input  logic [lir_pkg::LIR_RATE_W-1:0]      cfg_data,
  lir_in_if.sink                              in_ch,
  lir_out_if.source                           out_ch
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV,
    ST_CHECK,
    ST_ISSUE,
    ST_DRAIN,
    ST_EMIT,
    ST_PASS,
    ST_FINISH
  } state_t;

  localparam int unsigned LN = lir_pkg::LIR_LANES;
  localparam int unsigned LW = lir_pkg::LIR_LANE_W;
  localparam int unsigned FW = lir_pkg::LIR_FRAC_W;
  localparam int unsigned PW = lir_pkg::LIR_POS_W;
  localparam int unsigned CW = lir_pkg::LIR_CNT_W;

  state_t                                  state_r;

  // configuration registers
  logic [lir_pkg::LIR_RATE_W-1:0]          src_rate_r;
  logic [lir_pkg::LIR_RATE_W-1:0]          tgt_rate_r;
  logic [lir_pkg::LIR_CHAN_W-1:0]          chan_cnt_r;
  logic                                    fmt_r;

  // block state
  lir_pkg::lir_sample_t                    cur_r   [LN];
  lir_pkg::lir_sample_t                    prev_r  [LN];
  lir_pkg::lir_sample_t                    frame_r [LN];
  logic                                    have_prev_r;
  logic [PW-1:0]                           pos_r;
  logic                                    wrap_r;
  logic [PW-1:0]                           step_r;
  logic [CW-1:0]                           in_cnt_r;
  logic [CW-1:0]                           out_cnt_r;
  logic [lir_pkg::LIR_LIMIT_W-1:0]         limit_r;
  logic [lir_pkg::LIR_RUN_W-1:0]           run_r;
  logic [LW-1:0]                           lane_r;

  // result register
  logic                                    out_valid_r;
  lir_pkg::lir_sample_t                    out_data_r [LN];
  logic                                    out_last_r;

  lir_pkg::lir_sample_t                    in_samp [LN];
  logic [lir_pkg::LIR_CHAN_W-1:0]          lanes_act;
  logic                                    in_acc;
  logic                                    pass_sel;
  logic                                    div_start;
  logic                                    div_done;
  logic [lir_pkg::LIR_DIVD_W-1:0]          div_q;
  logic [PW-1:0]                           step_clamped;
  logic [CW-1:0]                           in_cnt_m1;
  logic                                    more_ok;
  logic                                    out_free;
  logic [PW:0]                             pos_sum;
  lir_pkg::lir_req_t                       req;
  lir_pkg::lir_res_t                       res;

  always_comb begin
    in_samp[0] = in_ch.sample_in_0;
    in_samp[1] = in_ch.sample_in_1;
    in_samp[2] = in_ch.sample_in_2;
    in_samp[3] = in_ch.sample_in_3;
    in_samp[4] = in_ch.sample_in_4;
    in_samp[5] = in_ch.sample_in_5;
    in_samp[6] = in_ch.sample_in_6;
    in_samp[7] = in_ch.sample_in_7;
  end

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;

  // Counts above the lane count clip to all lanes.
  assign lanes_act = (chan_cnt_r > lir_pkg::LIR_CHAN_W'(LN))
                   ? lir_pkg::LIR_CHAN_W'(LN) : chan_cnt_r;

  // Equal rates or no lanes at block start select pass-through (step 0).
  assign pass_sel  = (src_rate_r == tgt_rate_r) || (chan_cnt_r == '0);
  assign div_start = in_acc && in_ch.block_start && !pass_sel;

  // A zero divisor yields all ones, which saturates like any large quotient.
  always_comb begin
    if (div_q[lir_pkg::LIR_DIVD_W-1:PW] != '0) begin
      step_clamped = '1;
    end else if (div_q[PW-1:0] < lir_pkg::LIR_MIN_STEP) begin
      step_clamped = lir_pkg::LIR_MIN_STEP;
    end else begin
      step_clamped = div_q[PW-1:0];
    end
  end

  // Next output frame exists when its integer position equals the
  // previous frame index and neither run nor block limit is reached.
  assign in_cnt_m1 = in_cnt_r - 1'b1;
  assign more_ok   = (run_r < lir_pkg::LIR_RUN_W'(lir_pkg::LIR_MAX_RUN))
                  && (out_cnt_r < {1'b0, limit_r})
                  && ({1'b0, pos_r[PW-1:FW]} == in_cnt_m1);
  assign pos_sum   = {1'b0, pos_r} + {1'b0, step_r};

  always_comb begin
    req.valid = (state_r == ST_ISSUE);
    req.lane  = lane_r;
    req.s0    = prev_r[lane_r];
    req.s1    = cur_r[lane_r];
    req.frac  = pos_r[FW-1:0];
  end

  lir_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend ({src_rate_r, FW'(0)}),
    .divisor  (tgt_rate_r),
    .done     (div_done),
    .quotient (div_q)
  );

  lir_interp u_interp (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .fmt   (fmt_r),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      src_rate_r  <= lir_pkg::LIR_RATE_W'(48000);
      tgt_rate_r  <= lir_pkg::LIR_RATE_W'(48000);
      chan_cnt_r  <= lir_pkg::LIR_CHAN_W'(2);
      fmt_r       <= lir_pkg::LIR_FMT_S16;
      have_prev_r <= 1'b0;
      pos_r       <= '0;
      wrap_r      <= 1'b0;
      step_r      <= '0;
      in_cnt_r    <= '0;
      out_cnt_r   <= '0;
      limit_r     <= '0;
      run_r       <= '0;
      lane_r      <= '0;
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (lir_pkg::lir_cfg_idx_t'(cfg_index))
          lir_pkg::CFG_SOURCE_RATE:   src_rate_r <= cfg_data;
          lir_pkg::CFG_TARGET_RATE:   tgt_rate_r <= cfg_data;
          lir_pkg::CFG_CHANNEL_COUNT: chan_cnt_r <= cfg_data[lir_pkg::LIR_CHAN_W-1:0];
          lir_pkg::CFG_SAMPLE_FORMAT: fmt_r      <= cfg_data[0];
        endcase
      end

      // drop the result once taken; a new frame below overrides this
      if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            run_r <= '0;
            if (in_ch.block_start) begin
              limit_r     <= in_ch.output_limit;
              pos_r       <= '0;
              in_cnt_r    <= '0;
              out_cnt_r   <= '0;
              have_prev_r <= 1'b0;
              if (pass_sel) begin
                step_r  <= '0;
                state_r <= ST_CHECK;
              end else begin
                state_r <= ST_DIV;
              end
            end else begin
              state_r <= ST_CHECK;
            end
          end
        end
        ST_DIV: begin
          if (div_done) begin
            step_r  <= step_clamped;
            state_r <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          if (step_r == '0) begin
            state_r <= (out_cnt_r < {1'b0, limit_r}) ? ST_PASS : ST_FINISH;
          end else if (have_prev_r && (in_cnt_r != '0) && more_ok) begin
            lane_r  <= '0;
            state_r <= ST_ISSUE;
          end else begin
            state_r <= ST_FINISH;
          end
        end
        ST_ISSUE: begin
          lane_r <= lane_r + 1'b1;
          if (lane_r == LW'(LN - 1)) begin
            // frac of every lane is in flight: advance position and counts
            {wrap_r, pos_r} <= pos_sum;
            out_cnt_r       <= out_cnt_r + 1'b1;
            run_r           <= run_r + 1'b1;
            state_r         <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (res.valid && (res.lane == LW'(LN - 1))) begin
            state_r <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_last_r  <= !(!wrap_r && more_ok);
            if (!wrap_r && more_ok) begin
              lane_r  <= '0;
              state_r <= ST_ISSUE;
            end else begin
              state_r <= ST_FINISH;
            end
          end
        end
        ST_PASS: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_last_r  <= 1'b1;
            out_cnt_r   <= out_cnt_r + 1'b1;
            state_r     <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          have_prev_r <= 1'b1;
          if (in_cnt_r != lir_pkg::LIR_CNT_MAX) begin
            in_cnt_r <= in_cnt_r + 1'b1;
          end
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // Sample payload: capture, hold frame, assemble lanes, load result.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      for (int c = 0; c < LN; c++) begin
        cur_r[c] <= lir_pkg::sat_fmt($signed({{3{in_samp[c][lir_pkg::LIR_SAMPLE_W-1]}},
                                              in_samp[c]}), fmt_r);
      end
    end
    if (state_r == ST_FINISH) begin
      for (int c = 0; c < LN; c++) begin
        prev_r[c] <= cur_r[c];
      end
    end
    if (res.valid) begin
      frame_r[res.lane] <= ({1'b0, res.lane} < lanes_act) ? res.value : '0;
    end
    if ((state_r == ST_EMIT) && out_free) begin
      for (int c = 0; c < LN; c++) begin
        out_data_r[c] <= frame_r[c];
      end
    end
    if ((state_r == ST_PASS) && out_free) begin
      for (int c = 0; c < LN; c++) begin
        out_data_r[c] <= (lir_pkg::LIR_CHAN_W'(c) < lanes_act) ? cur_r[c] : '0;
      end
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.last_of_run  = out_last_r;
  assign out_ch.sample_out_0 = out_data_r[0];
  assign out_ch.sample_out_1 = out_data_r[1];
  assign out_ch.sample_out_2 = out_data_r[2];
  assign out_ch.sample_out_3 = out_data_r[3];
  assign out_ch.sample_out_4 = out_data_r[4];
  assign out_ch.sample_out_5 = out_data_r[5];
  assign out_ch.sample_out_6 = out_data_r[6];
  assign out_ch.sample_out_7 = out_data_r[7];

endmodule

`default_nettype wire

@@ src/lir_div.sv @@
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module lir_div (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic [lir_pkg::LIR_DIVD_W-1:0]   dividend,
  input  logic [lir_pkg::LIR_RATE_W-1:0]   divisor,
  output logic                             done,
  output logic [lir_pkg::LIR_DIVD_W-1:0]   quotient
);

  localparam int unsigned CNT_W = $clog2(lir_pkg::LIR_DIVD_W);

  logic                             busy_r;
  logic                             done_r;
  logic [CNT_W-1:0]                 cnt_r;
  logic [lir_pkg::LIR_RATE_W-1:0]   dsr_r;
  logic [lir_pkg::LIR_RATE_W-1:0]   rem_r;
  logic [lir_pkg::LIR_DIVD_W-1:0]   quo_r;
  logic [lir_pkg::LIR_RATE_W:0]     rem_sh;
  logic                             fits;
  logic [lir_pkg::LIR_RATE_W:0]     rem_sub;

  always_comb begin
    rem_sh  = {rem_r, quo_r[lir_pkg::LIR_DIVD_W-1]};
    fits    = (rem_sh >= {1'b0, dsr_r});
    rem_sub = rem_sh - {1'b0, dsr_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(lir_pkg::LIR_DIVD_W - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Dividend bits shift out the top while quotient bits shift in below.
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dsr_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[lir_pkg::LIR_DIVD_W-2:0], fits};
      rem_r <= fits ? rem_sub[lir_pkg::LIR_RATE_W-1:0] : rem_sh[lir_pkg::LIR_RATE_W-1:0];
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

@@ src/lir_interp.sv @@
`default_nettype none

// Shared lane unit: s0 + round((s1 - s0) * frac / 2^16), saturated.
// Three stages, one lane job accepted per cycle.
module lir_interp (
  input  logic              clk,
  input  logic              rst_n,
  input  lir_pkg::lir_req_t req,
  input  logic              fmt,
  output lir_pkg::lir_res_t res
);

  localparam int unsigned DIFF_W = lir_pkg::LIR_SAMPLE_W + 1;
  localparam int unsigned PROD_W = DIFF_W + lir_pkg::LIR_FRAC_W + 1;
  localparam int unsigned SH_W   = PROD_W - lir_pkg::LIR_FRAC_W;

  logic                                 v1_r;
  logic [lir_pkg::LIR_LANE_W-1:0]       lane1_r;
  logic signed [DIFF_W-1:0]             d1_r;
  lir_pkg::lir_sample_t                 s0_1_r;
  logic [lir_pkg::LIR_FRAC_W-1:0]       frac1_r;

  logic                                 v2_r;
  logic [lir_pkg::LIR_LANE_W-1:0]       lane2_r;
  logic signed [PROD_W-1:0]             prod2_r;
  lir_pkg::lir_sample_t                 s0_2_r;

  logic                                 res_valid_r;
  logic [lir_pkg::LIR_LANE_W-1:0]       res_lane_r;
  lir_pkg::lir_sample_t                 res_value_r;

  logic signed [DIFF_W-1:0]             diff_nxt;
  logic signed [PROD_W-1:0]             prod_nxt;
  logic signed [PROD_W-1:0]             rnd;
  logic signed [SH_W-1:0]               sh;
  logic signed [lir_pkg::LIR_WIDE_W-1:0] sum;

  always_comb begin
    diff_nxt = $signed({req.s1[lir_pkg::LIR_SAMPLE_W-1], req.s1})
             - $signed({req.s0[lir_pkg::LIR_SAMPLE_W-1], req.s0});
    prod_nxt = d1_r * $signed({1'b0, frac1_r});
    rnd      = prod2_r + $signed(PROD_W'(1) << (lir_pkg::LIR_FRAC_W - 1));
    sh       = $signed(rnd[PROD_W-1:lir_pkg::LIR_FRAC_W]);
    sum      = $signed({{3{s0_2_r[lir_pkg::LIR_SAMPLE_W-1]}}, s0_2_r})
             + $signed({sh[SH_W-1], sh});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      v1_r        <= req.valid;
      v2_r        <= v1_r;
      res_valid_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    lane1_r     <= req.lane;
    d1_r        <= diff_nxt;
    s0_1_r      <= req.s0;
    frac1_r     <= req.frac;
    lane2_r     <= lane1_r;
    prod2_r     <= prod_nxt;
    s0_2_r      <= s0_1_r;
    res_lane_r  <= lane2_r;
    res_value_r <= lir_pkg::sat_fmt(sum, fmt);
  end

  assign res = '{valid: res_valid_r, lane: res_lane_r, value: res_value_r};

endmodule

`default_nettype wire

@@ src/lir_chk.sv @@
`default_nettype none

`include "assert_macros.svh"

module lir_chk (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input lir_pkg::lir_sample_t out_sample_0,
  input logic                 out_last
);

  `LIR_ASSERT(a_out_hold_valid, clk, rst_n, out_valid && !out_ready |=> out_valid)
  `LIR_ASSERT(a_out_hold_data, clk, rst_n, out_valid && !out_ready |=> $stable(out_sample_0) && $stable(out_last))
  `LIR_ASSERT(a_busy_after_item, clk, rst_n, in_valid && in_ready |=> !in_ready)
  `LIR_ASSERT_RST(a_reset_idle, clk, !rst_n |=> in_ready && !out_valid)

endmodule

bind linear_interp_resampler lir_chk u_lir_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_sample_0 (out_ch.sample_out_0),
  .out_last     (out_ch.last_of_run)
);

`default_nettype wire

@@ tb/resampler_checker.sv @@
`timescale 1ns / 100ps

module resampler_checker import lir_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [LIR_CFG_IDX_W-1:0] cfg_index,
  input  logic [LIR_RATE_W-1:0]    cfg_data,
  lir_in_if                        in_ch,
  lir_out_if                       out_ch,
  output int unsigned              mismatch_count,
  output int unsigned              frames_awaited
);

  localparam int unsigned MAX_REPORTS = 10;

  typedef logic [LIR_LANES-1:0][LIR_SAMPLE_W-1:0] lane_set_t;

  typedef struct packed {
    logic      last;
    lane_set_t lanes;
  } resampled_frame_t;

  // Shadow of the configuration registers.
  logic [LIR_RATE_W-1:0]  source_hz;
  logic [LIR_RATE_W-1:0]  target_hz;
  logic [LIR_CHAN_W-1:0]  lane_count;
  logic                   sample_fmt;

  // Shadow of the interpolator state.
  longint                 held_lanes [LIR_LANES];
  logic                   held_valid;
  logic [LIR_POS_W-1:0]   phase_acc;
  logic [LIR_POS_W-1:0]   phase_inc;
  logic [LIR_CNT_W-1:0]   frames_in;
  logic [LIR_CNT_W-1:0]   frames_out;
  logic [LIR_LIMIT_W-1:0] frame_budget;

  resampled_frame_t       frames_due [$];
  resampled_frame_t       seen;
  resampled_frame_t       want;
  int unsigned            frames_checked;

  function automatic longint clamp_to_format(input longint v);
    longint hi;
    longint lo;
    hi = (sample_fmt == LIR_FMT_S32) ? 64'sd2147483647 : 64'sd32767;
    lo = (sample_fmt == LIR_FMT_S32) ? -64'sd2147483648 : -64'sd32768;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // 16.16 step from the two rates; zero selects pass-through.
  function automatic logic [LIR_POS_W-1:0] phase_increment();
    logic [63:0] quot;
    if (source_hz == target_hz || lane_count == '0) return '0;
    if (target_hz == '0) return '1;
    quot = (64'(source_hz) << LIR_FRAC_W) / 64'(target_hz);
    if (quot > 64'hFFFF_FFFF) return '1;
    if (quot < 64'(LIR_MIN_STEP)) return LIR_MIN_STEP;
    return quot[LIR_POS_W-1:0];
  endfunction

  task automatic interpolate_frame(input logic start, input logic [LIR_LIMIT_W-1:0] limit,
                                   input lane_set_t raw);
    longint           now_lanes [LIR_LANES];
    int unsigned      lanes_on;
    int unsigned      cur_index;
    int unsigned      runs;
    logic             more;
    longint           frac;
    longint           diff;
    longint           v;
    resampled_frame_t f;

    if (start) begin
      frame_budget = limit;
      phase_inc    = phase_increment();
      phase_acc    = '0;
      frames_in    = '0;
      frames_out   = '0;
      held_valid   = 1'b0;
      foreach (held_lanes[c]) held_lanes[c] = 0;
    end

    foreach (now_lanes[c]) begin
      now_lanes[c] = longint'($signed(raw[c]));
      if (sample_fmt == LIR_FMT_S16) now_lanes[c] = clamp_to_format(now_lanes[c]);
    end

    lanes_on  = (lane_count > LIR_LANES) ? LIR_LANES : lane_count;
    cur_index = frames_in;

    if (phase_inc == '0) begin
      if (frames_out < {1'b0, frame_budget}) begin
        f = '0;
        for (int c = 0; c < lanes_on; c++) begin
          v = clamp_to_format(now_lanes[c]);
          f.lanes[c] = v[LIR_SAMPLE_W-1:0];
        end
        f.last = 1'b1;
        frames_due.push_back(f);
        frames_out++;
      end
    end else if (held_valid && cur_index >= 1) begin
      runs = 0;
      more = (frames_out < {1'b0, frame_budget}) && (phase_acc[31:16] == cur_index - 1);
      while (more) begin
        f    = '0;
        frac = longint'(phase_acc[LIR_FRAC_W-1:0]);
        for (int c = 0; c < lanes_on; c++) begin
          diff = now_lanes[c] - held_lanes[c];
          v    = held_lanes[c] + ((diff * frac + 64'sd32768) >>> LIR_FRAC_W);
          v    = clamp_to_format(v);
          f.lanes[c] = v[LIR_SAMPLE_W-1:0];
        end
        frames_out++;
        phase_acc = phase_acc + phase_inc;
        runs++;
        // A wrapped accumulator ends the run for good.
        more = (runs < LIR_MAX_RUN) && (frames_out < {1'b0, frame_budget}) &&
               (phase_acc[31:16] == cur_index - 1) && !(phase_acc < phase_inc);
        f.last = !more;
        frames_due.push_back(f);
      end
    end

    foreach (held_lanes[c]) held_lanes[c] = now_lanes[c];
    held_valid = 1'b1;
    if (frames_in != LIR_CNT_MAX) frames_in++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      source_hz      = LIR_RATE_W'(48000);
      target_hz      = LIR_RATE_W'(48000);
      lane_count     = LIR_CHAN_W'(2);
      sample_fmt     = LIR_FMT_S16;
      held_valid     = 1'b0;
      phase_acc      = '0;
      phase_inc      = '0;
      frames_in      = '0;
      frames_out     = '0;
      frame_budget   = '0;
      mismatch_count = 0;
      frames_checked = 0;
      foreach (held_lanes[c]) held_lanes[c] = 0;
      frames_due.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        seen.last  = out_ch.last_of_run;
        seen.lanes = {out_ch.sample_out_7, out_ch.sample_out_6, out_ch.sample_out_5,
                      out_ch.sample_out_4, out_ch.sample_out_3, out_ch.sample_out_2,
                      out_ch.sample_out_1, out_ch.sample_out_0};
        if (frames_due.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("%0t: output frame %0d arrived with none expected", $time,
                     frames_checked);
        end else begin
          want = frames_due.pop_front();
          if (want != seen) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS) begin
              for (int c = 0; c < LIR_LANES; c++)
                if (want.lanes[c] != seen.lanes[c])
                  $display("%0t: frame %0d sample_out_%0d expected %0d got %0d", $time,
                           frames_checked, c, $signed(want.lanes[c]),
                           $signed(seen.lanes[c]));
              if (want.last != seen.last)
                $display("%0t: frame %0d last_of_run expected %0b got %0b", $time,
                         frames_checked, want.last, seen.last);
            end
          end
        end
        frames_checked++;
      end

      if (cfg_we) begin
        case (cfg_index)
          CFG_SOURCE_RATE:   source_hz  = cfg_data;
          CFG_TARGET_RATE:   target_hz  = cfg_data;
          CFG_CHANNEL_COUNT: lane_count = cfg_data[LIR_CHAN_W-1:0];
          CFG_SAMPLE_FORMAT: sample_fmt = cfg_data[0];
          default: ;
        endcase
      end

      if (in_ch.valid && in_ch.ready)
        interpolate_frame(in_ch.block_start, in_ch.output_limit,
                          {in_ch.sample_in_7, in_ch.sample_in_6, in_ch.sample_in_5,
                           in_ch.sample_in_4, in_ch.sample_in_3, in_ch.sample_in_2,
                           in_ch.sample_in_1, in_ch.sample_in_0});
    end
    frames_awaited <= frames_due.size();
  end

endmodule

@@ tb/tb_linear_interp_resampler.sv @@
`timescale 1ns / 100ps

module tb_linear_interp_resampler;
  import lir_pkg::*;

  localparam int unsigned RESET_CYCLES   = 9;
  // Longest quiet stretch of a correct run: a block start (divider) plus a
  // drain pause plus receiver stalls stays well below this.
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  // Drain pause: covers an item with a block start that causes no result.
  localparam int unsigned SETTLE_CYCLES  = 64;
  localparam int unsigned RANDOM_ITEMS   = 230;

  localparam logic [LIR_RATE_W-1:0] STD_RATES [11] = '{
    18'd8000, 18'd11025, 18'd16000, 18'd22050, 18'd32000, 18'd44100,
    18'd48000, 18'd88200, 18'd96000, 18'd176400, 18'd192000
  };

  typedef logic [LIR_LANES-1:0][LIR_SAMPLE_W-1:0] lane_set_t;

  logic                     clk = 1'b0;
  logic                     rst_n;
  logic                     cfg_we;
  logic [LIR_CFG_IDX_W-1:0] cfg_index;
  logic [LIR_RATE_W-1:0]    cfg_data;

  lir_in_if  in_ch ();
  lir_out_if out_ch ();

  int unsigned tx_gap_pct;
  int unsigned rx_stall_pct;
  int unsigned mismatches;
  int unsigned frames_awaited;
  int unsigned quiet_cycles;
  logic        cur_fmt;

  linear_interp_resampler dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  resampler_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_ch          (in_ch),
    .out_ch         (out_ch),
    .mismatch_count (mismatches),
    .frames_awaited (frames_awaited)
  );

  always #5 clk = ~clk;

  // Stall the result channel at the current rate.
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
  end

  // Bail out when neither channel nor the register port moves for too long.
  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("linear_interp_resampler test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic set_idling(input int unsigned tx_pct, input int unsigned rx_pct);
    tx_gap_pct = tx_pct;
    rx_stall_pct <= rx_pct;
  endtask

  // Write all four registers back to back; hold the enable across them.
  task automatic set_config(input logic [LIR_RATE_W-1:0] src, input logic [LIR_RATE_W-1:0] dst,
                            input logic [LIR_CHAN_W-1:0] lanes, input logic fmt);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_SOURCE_RATE;
    cfg_data  <= src;
    @(posedge clk);
    cfg_index <= CFG_TARGET_RATE;
    cfg_data  <= dst;
    @(posedge clk);
    cfg_index <= CFG_CHANNEL_COUNT;
    cfg_data  <= LIR_RATE_W'(lanes);
    @(posedge clk);
    cfg_index <= CFG_SAMPLE_FORMAT;
    cfg_data  <= LIR_RATE_W'(fmt);
    @(posedge clk);
    cfg_we  <= 1'b0;
    cur_fmt = fmt;
  endtask

  // Drop valid, wait for every predicted frame, then let the block go idle.
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (frames_awaited != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Offer one item, with a random gap in front, and hold it until taken.
  task automatic send_frame(input logic start, input logic [LIR_LIMIT_W-1:0] limit,
                            input lane_set_t lanes);
    while ($urandom_range(99) < tx_gap_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.block_start  <= start;
    in_ch.output_limit <= limit;
    in_ch.sample_in_0  <= lanes[0];
    in_ch.sample_in_1  <= lanes[1];
    in_ch.sample_in_2  <= lanes[2];
    in_ch.sample_in_3  <= lanes[3];
    in_ch.sample_in_4  <= lanes[4];
    in_ch.sample_in_5  <= lanes[5];
    in_ch.sample_in_6  <= lanes[6];
    in_ch.sample_in_7  <= lanes[7];
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  function automatic lane_set_t same_lanes(input logic [LIR_SAMPLE_W-1:0] v);
    return {LIR_LANES{v}};
  endfunction

  // Full-scale corners now and then; 16-bit mode mostly stays in range but
  // sometimes gets wide values so the input clamp is hit.
  function automatic logic [LIR_SAMPLE_W-1:0] pick_sample(input logic wide);
    logic [31:0] r;
    int unsigned roll;
    r    = $urandom;
    roll = $urandom_range(15);
    case (roll)
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_7FFF;
      3:       return 32'hFFFF_8000;
      4, 5:    return r;
      default: return wide ? r : {{16{r[15]}}, r[15:0]};
    endcase
  endfunction

  function automatic lane_set_t random_frame(input logic wide);
    lane_set_t lanes;
    for (int c = 0; c < LIR_LANES; c++) lanes[c] = pick_sample(wide);
    return lanes;
  endfunction

  // Mostly real audio rates, some arbitrary ones, and a few out-of-range.
  function automatic logic [LIR_RATE_W-1:0] pick_rate();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 70) return STD_RATES[$urandom_range(10)];
    if (roll < 90) return LIR_RATE_W'($urandom_range(192000, 8000));
    case ($urandom_range(3))
      0:       return '0;
      1:       return LIR_RATE_W'(1);
      2:       return '1;
      default: return LIR_RATE_W'($urandom);
    endcase
  endfunction

  function automatic logic [LIR_CHAN_W-1:0] pick_lane_count();
    if ($urandom_range(4) != 0) return LIR_CHAN_W'($urandom_range(8, 1));
    return ($urandom_range(1) == 0) ? '0 : LIR_CHAN_W'($urandom_range(15, 9));
  endfunction

  // Small limits so the cap is reached often; the rest open or arbitrary.
  function automatic logic [LIR_LIMIT_W-1:0] pick_limit();
    int unsigned roll;
    roll = $urandom_range(9);
    if (roll < 5) return LIR_LIMIT_W'($urandom_range(60));
    if (roll < 8) return '1;
    return LIR_LIMIT_W'($urandom);
  endfunction

  initial begin
    int unsigned      items_sent;
    int unsigned      run_len;
    logic [LIR_RATE_W-1:0] src;
    logic [LIR_RATE_W-1:0] dst;

    // Drive every input to a known value before the first edge.
    rst_n              <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_index          <= CFG_SOURCE_RATE;
    cfg_data           <= '0;
    in_ch.valid        <= 1'b0;
    in_ch.block_start  <= 1'b0;
    in_ch.output_limit <= '0;
    in_ch.sample_in_0  <= '0;
    in_ch.sample_in_1  <= '0;
    in_ch.sample_in_2  <= '0;
    in_ch.sample_in_3  <= '0;
    in_ch.sample_in_4  <= '0;
    in_ch.sample_in_5  <= '0;
    in_ch.sample_in_6  <= '0;
    in_ch.sample_in_7  <= '0;
    cur_fmt = LIR_FMT_S16;
    set_idling(36, 54);

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // No block opened yet: step and limit are zero, so nothing comes out.
    send_frame(1'b0, '1, same_lanes(32'h7FFF_FFFF));

    // Reset rates are equal: pass-through with a limit of three. Wide inputs
    // get clamped to 16 bits; the fourth item is over the limit.
    send_frame(1'b1, 16'd3, {32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_7FFF, 32'hFFFF_8000,
                             32'h0000_8000, 32'hFFFF_7FFF, 32'h0000_0000, 32'hFFFF_FFFF});
    send_frame(1'b0, 16'd0, {32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_7FFF, 32'h0000_8000,
                             32'hFFFF_8000, 32'h0000_7FFF, 32'h8000_0000, 32'h7FFF_FFFF});
    send_frame(1'b0, 16'd0, same_lanes(32'h0000_1234));
    send_frame(1'b0, 16'd0, same_lanes(32'hFFFF_EDCC));
    settle();

    // Steepest upsampling on all lanes in 32-bit: full-scale swings, up to a
    // full run of frames per item.
    set_config(18'd8000, 18'd192000, 4'd8, LIR_FMT_S32);
    send_frame(1'b1, '1, same_lanes(32'h7FFF_FFFF));
    send_frame(1'b0, 16'd0, same_lanes(32'h8000_0000));
    send_frame(1'b0, 16'd0, same_lanes(32'h7FFF_FFFF));
    settle();

    // Change lane count and format inside the block: they apply at once,
    // the new rates wait for the next block start.
    set_config(18'd44100, 18'd48000, 4'd3, LIR_FMT_S16);
    send_frame(1'b0, '1, {32'h0001_0000, 32'hFFFE_0000, 32'h0000_7FFF, 32'hFFFF_8000,
                          32'h1234_5678, 32'h8765_4321, 32'h0000_0001, 32'hFFFF_FFFF});
    send_frame(1'b0, 16'd0, same_lanes(32'hFFFF_8000));
    send_frame(1'b0, 16'd0, same_lanes(32'h0000_7FFF));
    settle();

    // Zero lane count forces pass-through with every lane zeroed.
    set_config(18'd44100, 18'd48000, 4'd0, LIR_FMT_S16);
    send_frame(1'b1, 16'd2, random_frame(1'b0));
    send_frame(1'b0, 16'd0, random_frame(1'b0));
    settle();

    // Zero target rate saturates the step; lane count above eight acts as eight.
    set_config(18'd96000, 18'd0, 4'd15, LIR_FMT_S32);
    send_frame(1'b1, 16'd10, random_frame(1'b1));
    send_frame(1'b0, 16'd0, random_frame(1'b1));
    settle();

    // Quotient too big for 32 bits: step saturates too.
    set_config('1, 18'd1, 4'd4, LIR_FMT_S32);
    send_frame(1'b1, 16'd5, random_frame(1'b1));
    send_frame(1'b0, 16'd0, random_frame(1'b1));
    settle();

    // Quotient below the floor: step is raised to the minimum.
    set_config(18'd1, '1, 4'd2, LIR_FMT_S16);
    send_frame(1'b1, '1, random_frame(1'b0));
    send_frame(1'b0, 16'd0, random_frame(1'b0));

    // A block with a zero limit stays silent whatever follows.
    send_frame(1'b1, 16'd0, random_frame(1'b0));
    send_frame(1'b0, '1, random_frame(1'b0));

    // Random blocks: mostly fresh settings, sometimes a restart on the fly.
    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      if (items_sent >= 147) begin
        set_idling(0, 0);
      end else if (items_sent >= 63) begin
        set_idling(54, 36);
      end
      if ($urandom_range(4) != 0) begin
        settle();
        src = pick_rate();
        dst = ($urandom_range(9) == 0) ? src : pick_rate();
        set_config(src, dst, pick_lane_count(), 1'($urandom_range(1)));
      end
      send_frame(1'b1, pick_limit(), random_frame(cur_fmt));
      items_sent++;
      run_len = $urandom_range(12, 1);
      repeat (run_len) begin
        send_frame(1'b0, LIR_LIMIT_W'($urandom), random_frame(cur_fmt));
        items_sent++;
      end
    end

    settle();
    if (mismatches == 0 && frames_awaited == 0) begin
      $display("linear_interp_resampler test passed");
    end else begin
      $display("linear_interp_resampler test failed");
    end
    $finish;
  end

endmodule

@@ linear_interp_resampler.f @@
+incdir+src
src/lir_pkg.sv
src/lir_ifs.sv
src/lir_div.sv
src/lir_interp.sv
src/linear_interp_resampler.sv
src/lir_chk.sv
tb/resampler_checker.sv
tb/tb_linear_interp_resampler.sv
